[rtl/cfp_pkg.sv]
`timescale 1ns / 1ps
package cfp_pkg;

  // Frame length limit and the counter widths that follow from it
  localparam int MaxFrameBytes = 64;
  localparam int CntW          = $clog2(MaxFrameBytes + 1);
  localparam int MinW          = 7;
  localparam int CmpW          = (CntW > MinW) ? CntW : MinW;

  // Register indexes on the configuration port
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegHeader    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFooter    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSeparator = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMinFrame  = 2'd3;

  // Register reset values
  localparam logic [7:0]      HeaderRst    = 8'd97;
  localparam logic [7:0]      FooterRst    = 8'd98;
  localparam logic [7:0]      SeparatorRst = 8'd44;
  localparam logic [MinW-1:0] MinFrameRst  = 7'd4;

  // Character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [31:0] MagCap = 32'h8000_0000;
  localparam logic [31:0] PosMax = 32'h7FFF_FFFF;

  // Result status codes
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef enum logic [2:0] {
    PH_XWS    = 3'd0,
    PH_XSIGN  = 3'd1,
    PH_XDIG   = 3'd2,
    PH_YSTART = 3'd3,
    PH_YWS    = 3'd4,
    PH_YSIGN  = 3'd5,
    PH_YDIG   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0]      header;
    logic [7:0]      footer;
    logic [7:0]      separator;
    logic [MinW-1:0] min_frame;
  } cfg_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } result_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  // mag * 10 + digit, saturating at the magnitude cap
  function automatic logic [31:0] accumulate(input logic [31:0] mag, input logic [7:0] b);
    logic [35:0] v;
    v = (36'(mag) << 3) + (36'(mag) << 1) + 36'(b - ChZero);
    return (v > 36'(MagCap)) ? MagCap : v[31:0];
  endfunction

  function automatic logic [31:0] to_signed32(input logic neg, input logic [31:0] mag);
    if (neg) begin
      return (mag >= MagCap) ? MagCap : (32'd0 - mag);
    end
    return (mag >= MagCap) ? PosMax : mag;
  endfunction

endpackage

[rtl/cfp_parse.sv]
`timescale 1ns / 1ps
module cfp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       rx_byte,
  input  cfp_pkg::cfg_t    cfg,
  output logic             res_valid,
  output cfp_pkg::result_t res
);
  import cfp_pkg::*;

  logic                     in_frame_r, in_frame_nxt;
  logic [CntW-1:0]          cnt_r, cnt_nxt, cnt_inc;
  phase_t                   phase_r, phase_nxt, phase_b;
  logic                     bad_r, bad_nxt, bad_b;
  logic                     xn_r, xn_nxt, xn_b;
  logic                     yn_r, yn_nxt, yn_b;
  logic [31:0]              xm_r, xm_nxt, xm_b;
  logic [31:0]              ym_r, ym_nxt, ym_b;
  logic [31:0]              last_x_r, last_x_nxt;
  logic [31:0]              last_y_r, last_y_nxt;
  logic                     sign_b, ok;
  logic [31:0]              acc_x, acc_y;

  assign cnt_inc = cnt_r + 1'b1;
  assign sign_b  = (rx_byte == ChPlus) || (rx_byte == ChMinus);
  assign acc_x   = accumulate(xm_r, rx_byte);
  assign acc_y   = accumulate(ym_r, rx_byte);
  assign ok      = !bad_r && ((phase_r == PH_YSTART) || (phase_r == PH_YDIG));

  // Body grammar: next parse state for a non-footer byte
  always_comb begin
    phase_b = phase_r;
    bad_b   = bad_r;
    xn_b    = xn_r;
    yn_b    = yn_r;
    xm_b    = xm_r;
    ym_b    = ym_r;
    if (!bad_r) begin
      unique case (phase_r)
        PH_XWS: begin
          if (rx_byte == cfg.separator) bad_b = 1'b1;
          else if (is_space(rx_byte)) bad_b = 1'b0;
          else if (sign_b) begin
            xn_b    = (rx_byte == ChMinus);
            phase_b = PH_XSIGN;
          end else if (is_digit(rx_byte)) begin
            xm_b    = acc_x;
            phase_b = PH_XDIG;
          end else bad_b = 1'b1;
        end
        PH_XSIGN: begin
          if ((rx_byte != cfg.separator) && is_digit(rx_byte)) begin
            xm_b    = acc_x;
            phase_b = PH_XDIG;
          end else bad_b = 1'b1;
        end
        PH_XDIG: begin
          if (rx_byte == cfg.separator) phase_b = PH_YSTART;
          else if (is_digit(rx_byte)) xm_b = acc_x;
          else bad_b = 1'b1;
        end
        PH_YSTART, PH_YWS: begin
          if (is_space(rx_byte)) phase_b = PH_YWS;
          else if (sign_b) begin
            yn_b    = (rx_byte == ChMinus);
            phase_b = PH_YSIGN;
          end else if (is_digit(rx_byte)) begin
            ym_b    = acc_y;
            phase_b = PH_YDIG;
          end else bad_b = 1'b1;
        end
        PH_YSIGN, PH_YDIG: begin
          if (is_digit(rx_byte)) begin
            ym_b    = acc_y;
            phase_b = PH_YDIG;
          end else bad_b = 1'b1;
        end
        default: bad_b = 1'b1;
      endcase
    end
  end

  // Framing: hunt, store, close on footer or drop on overrun
  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    phase_nxt    = phase_r;
    bad_nxt      = bad_r;
    xn_nxt       = xn_r;
    yn_nxt       = yn_r;
    xm_nxt       = xm_r;
    ym_nxt       = ym_r;
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    res_valid    = 1'b0;
    if (acc) begin
      if (!in_frame_r) begin
        if (rx_byte == cfg.header) in_frame_nxt = 1'b1;
      end else if (rx_byte != cfg.footer) begin
        cnt_nxt   = cnt_inc;
        phase_nxt = phase_b;
        bad_nxt   = bad_b;
        xn_nxt    = xn_b;
        yn_nxt    = yn_b;
        xm_nxt    = xm_b;
        ym_nxt    = ym_b;
        if (cnt_inc == CntW'(MaxFrameBytes)) in_frame_nxt = 1'b0;
      end else begin
        in_frame_nxt = 1'b0;
        if (CmpW'(cnt_inc) >= CmpW'(cfg.min_frame)) begin
          res_valid = 1'b1;
          if (ok) begin
            last_x_nxt = to_signed32(xn_r, xm_r);
            last_y_nxt = to_signed32(yn_r, ym_r);
          end
        end
      end
      // leaving a frame always clears the parse state
      if (in_frame_r && !in_frame_nxt) begin
        cnt_nxt   = '0;
        phase_nxt = PH_XWS;
        bad_nxt   = 1'b0;
        xn_nxt    = 1'b0;
        yn_nxt    = 1'b0;
        xm_nxt    = '0;
        ym_nxt    = '0;
      end
    end
    res.status = ok ? StatusOk : StatusFail;
    res.x      = last_x_nxt;
    res.y      = last_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      phase_r    <= PH_XWS;
      bad_r      <= 1'b0;
      xn_r       <= 1'b0;
      yn_r       <= 1'b0;
      xm_r       <= '0;
      ym_r       <= '0;
      last_x_r   <= '0;
      last_y_r   <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
      phase_r    <= phase_nxt;
      bad_r      <= bad_nxt;
      xn_r       <= xn_nxt;
      yn_r       <= yn_nxt;
      xm_r       <= xm_nxt;
      ym_r       <= ym_nxt;
      last_x_r   <= last_x_nxt;
      last_y_r   <= last_y_nxt;
    end
  end

`ifndef SYNTHESIS
  // a result only comes from a footer closing an open frame
  a_res_on_footer: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (acc && in_frame_r && (rx_byte == cfg.footer)))
    else $error("result without closing footer");

  // hunting state holds no partial frame
  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> ((cnt_r == '0) && !bad_r && (phase_r == PH_XWS)))
    else $error("stale parse state while hunting");

  // a failed frame leaves the last good coordinates alone
  a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == StatusFail)) |=>
      ($stable(last_x_r) && $stable(last_y_r)))
    else $error("coordinates changed on malformed frame");
`endif

endmodule

[rtl/cfp_out_buf.sv]
`timescale 1ns / 1ps
module cfp_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfp_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output cfp_pkg::result_t out_data
);
  import cfp_pkg::*;

  result_t    ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // two-entry queue so the parser keeps taking bytes while a result waits
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  // no write lands on a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result queue overflow");
`endif

endmodule

[rtl/coordinate_frame_parser_unit.sv]
`timescale 1ns / 1ps
// Coordinate frame parser: one received byte per transfer, one byte a cycle sustained while
// the result queue has room. A closing footer byte writes its result into that queue, which
// presents it on out_*; the two-entry result queue lets input keep flowing while a result
// waits, input stalls only with two results pending.
// Reset (synchronous, rst_n low): registers to defaults, hunting, coordinates zero.
module coordinate_frame_parser_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_frame_status,
  output logic signed [31:0]              out_coord_x,
  output logic signed [31:0]              out_coord_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfp_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [7:0]                      cfg_wdata
);
  import cfp_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    acc, full, res_valid;
  result_t res, out_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign acc       = in_valid && in_ready;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        RegHeader:    cfg_nxt.header    = cfg_wdata;
        RegFooter:    cfg_nxt.footer    = cfg_wdata;
        RegSeparator: cfg_nxt.separator = cfg_wdata;
        RegMinFrame:  cfg_nxt.min_frame = cfg_wdata[MinW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header    <= HeaderRst;
      cfg_r.footer    <= FooterRst;
      cfg_r.separator <= SeparatorRst;
      cfg_r.min_frame <= MinFrameRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  cfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_frame_status = out_data.status;
  assign out_coord_x      = out_data.x;
  assign out_coord_y      = out_data.y;

endmodule
